### rtl/amb_pkg.sv
// Shared types, constants and elaboration-time helpers for the affine model matrix builder.
// Depends on nothing; every other file in rtl but amb_queue refers to it by scoped names.
package amb_pkg;

  // Quarter turn in radians, Q30.
  localparam logic [31:0] PI_HALF_Q30 = 32'd1686629713;

  // Fixed widths of the scale and position fields.
  localparam int SCALE_W = 24;
  localparam int POS_W   = 32;
  localparam int ENTRY_W = 32;

  // One input transaction: three angles, a position and three scale factors.
  typedef struct packed {
    logic        [15:0] rot_x_turns;
    logic        [15:0] rot_y_turns;
    logic        [15:0] rot_z_turns;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [23:0] scale_x;
    logic signed [23:0] scale_y;
    logic signed [23:0] scale_z;
  } in_item_t;

  // One result transaction: one column of the forward and the inverse matrix.
  typedef struct packed {
    logic         [1:0] column_index;
    logic signed [31:0] fwd_e0;
    logic signed [31:0] fwd_e1;
    logic signed [31:0] fwd_e2;
    logic signed [31:0] fwd_e3;
    logic signed [31:0] inv_e0;
    logic signed [31:0] inv_e1;
    logic signed [31:0] inv_e2;
    logic signed [31:0] inv_e3;
    logic               zero_scale;
    logic               last_column;
  } out_item_t;

  // Quarter-wave sine entry, evaluated only at elaboration to fill the lookup table.
  // A Taylor sum up to the x^13 term in Q30 radians, rounded to frac bits and clamped.
  function automatic logic [31:0] quarter_sine(input int r, input int tbits, input int frac);
    logic        [63:0] x;
    logic        [63:0] x2;
    logic        [63:0] term;
    logic signed [63:0] sum;
    logic signed [63:0] w;
    logic signed [63:0] res;
    logic signed [63:0] one;
    x    = (64'(PI_HALF_Q30) * 64'(r)) >> (tbits - 2);
    x2   = (x * x) >> 30;
    term = x;
    sum  = signed'(x);
    for (int k = 1; k <= 6; k++) begin
      term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
      if ((k & 1) != 0) begin
        sum = sum - signed'(term);
      end else begin
        sum = sum + signed'(term);
      end
    end
    one = 64'sd1 <<< frac;
    w   = sum + (64'sd1 <<< (29 - frac));
    res = w >>> (30 - frac);
    if (res < 0) begin
      res = 0;
    end
    if (res > one) begin
      res = one;
    end
    return res[31:0];
  endfunction

endpackage

### rtl/amb_recip.sv
// Pipelined restoring divider that forms the three scale reciprocals, one quotient bit a stage.
// Depends on amb_pkg for the input transaction type, which rides along unchanged.
module amb_recip #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               valid_in,
  input  amb_pkg::in_item_t  item_in,
  output logic               valid_out,
  output amb_pkg::in_item_t  item_out,
  output logic signed [31:0] rcp [3],
  output logic               zero
);

  localparam int NW = 2 * FRAC_BITS + 1;
  localparam int MW = amb_pkg::SCALE_W;
  localparam logic [NW-1:0] NUM_ONE = NW'(1) << (2 * FRAC_BITS);

  logic [NW-1:0]     num  [3][NW+1];
  logic [NW-1:0]     quo  [3][NW+1];
  logic [MW-1:0]     rem  [3][NW+1];
  logic [MW-1:0]     mag  [3][NW+1];
  logic              neg  [3][NW+1];
  logic              zs   [3][NW+1];
  logic              vld  [NW+1];
  amb_pkg::in_item_t itm  [NW+1];
  logic [MW:0]       trial[3][NW];
  logic              ge   [3][NW];
  logic signed [MW-1:0] sc_in [3];
  logic        [MW:0]   abs_in[3];
  logic [63:0]          qx    [3];
  logic                 ovf   [3];

  // Magnitude of each scale factor at the entry of the divider.
  always_comb begin
    sc_in[0] = item_in.scale_x;
    sc_in[1] = item_in.scale_y;
    sc_in[2] = item_in.scale_z;
    for (int l = 0; l < 3; l++) begin
      abs_in[l] = sc_in[l][MW-1] ? (MW+1)'(-(MW+1)'(sc_in[l])) : (MW+1)'(sc_in[l]);
    end
  end

  // One trial subtraction per stage and lane.
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      for (int s = 0; s < NW; s++) begin
        trial[l][s] = {rem[l][s], num[l][s][NW-1]};
        ge[l][s]    = trial[l][s] >= {1'b0, mag[l][s]};
      end
    end
  end

  // Valid bits of the divider stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s <= NW; s++) begin
        vld[s] <= 1'b0;
      end
      valid_out <= 1'b0;
    end else begin
      vld[0] <= valid_in;
      for (int s = 0; s < NW; s++) begin
        vld[s+1] <= vld[s];
      end
      valid_out <= vld[NW];
    end
  end

  // Stage payload: load, then shift a numerator bit into the remainder each stage.
  always_ff @(posedge clk) begin
    itm[0] <= item_in;
    for (int l = 0; l < 3; l++) begin
      mag[l][0] <= abs_in[l][MW-1:0];
      num[l][0] <= NUM_ONE + NW'(abs_in[l][MW-1:1]);
      rem[l][0] <= '0;
      quo[l][0] <= '0;
      neg[l][0] <= sc_in[l][MW-1];
      zs[l][0]  <= (sc_in[l] == '0);
    end
    for (int s = 0; s < NW; s++) begin
      itm[s+1] <= itm[s];
      for (int l = 0; l < 3; l++) begin
        mag[l][s+1] <= mag[l][s];
        neg[l][s+1] <= neg[l][s];
        zs[l][s+1]  <= zs[l][s];
        num[l][s+1] <= num[l][s] << 1;
        quo[l][s+1] <= {quo[l][s][NW-2:0], ge[l][s]};
        rem[l][s+1] <= ge[l][s] ? MW'(trial[l][s] - {1'b0, mag[l][s]}) : trial[l][s][MW-1:0];
      end
    end
  end

  // Overflow check on the finished quotient.
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      qx[l]  = 64'(quo[l][NW]);
      ovf[l] = |qx[l][63:31];
    end
  end

  // Sign, saturation and the zero-scale override.
  always_ff @(posedge clk) begin
    item_out <= itm[NW];
    zero     <= zs[0][NW] | zs[1][NW] | zs[2][NW];
    for (int l = 0; l < 3; l++) begin
      if (zs[l][NW]) begin
        rcp[l] <= 32'sh7FFFFFFF;
      end else if (neg[l][NW]) begin
        rcp[l] <= ovf[l] ? 32'sh80000000 : -signed'(qx[l][31:0]);
      end else begin
        rcp[l] <= ovf[l] ? 32'sh7FFFFFFF : signed'(qx[l][31:0]);
      end
    end
  end

endmodule

### rtl/amb_front.sv
// Front end: reciprocal pipeline, sine/cosine lookup and the 3x3 rotation product.
// Depends on amb_pkg and amb_recip; emits one packed work item per accepted transaction.
module amb_front #(
  parameter int FRAC_BITS       = 16,
  parameter int SINE_TABLE_BITS = 10,
  parameter int RW              = 19,
  parameter int ITEM_W          = 436
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              valid_in,
  input  amb_pkg::in_item_t item,
  output logic              valid_out,
  output logic [ITEM_W-1:0] data_out
);

  localparam int T      = SINE_TABLE_BITS;
  localparam int QN     = 1 << (T - 2);
  localparam int SW     = FRAC_BITS + 2;
  localparam int PRW    = SW + RW;
  localparam int SIDE_W = ITEM_W - 9 * RW;
  localparam logic signed [PRW:0] HALF_P = 1 << (FRAC_BITS - 1);
  localparam logic [T-1:0] QTR = T'(QN);

  logic [FRAC_BITS:0] qsin [QN+1];

  logic                 d_valid;
  amb_pkg::in_item_t    d_item;
  logic signed [31:0]   d_rcp [3];
  logic                 d_zero;

  logic                    v1, v2, v3;
  logic signed [SW-1:0]    sx1, cx1, sy1, cy1, sz1, cz1;
  logic signed [SW-1:0]    sx2, cx2, sy2, cy2, sz2, cz2;
  logic signed [2*SW-1:0]  m_sysx, m_sycx, m_cysx, m_cycx;
  logic [SIDE_W-1:0]       side1, side2, side3;
  logic signed [RW-1:0]    t0 [3];
  logic signed [RW-1:0]    t1 [3];
  logic signed [RW-1:0]    t2 [3];
  logic signed [PRW-1:0]   pa [3];
  logic signed [PRW-1:0]   pb [3];
  logic signed [PRW-1:0]   pc [3];
  logic signed [PRW-1:0]   pd [3];
  logic signed [RW-1:0]    t2r [3];
  logic signed [RW-1:0]    r0 [3];
  logic signed [RW-1:0]    r1 [3];

  // Quarter-wave sine table, filled at elaboration.
  for (genvar g = 0; g <= QN; g++) begin : g_tab
    assign qsin[g] = (FRAC_BITS+1)'(amb_pkg::quarter_sine(g, T, FRAC_BITS));
  end

  // Full-turn sine from the quarter table by quadrant symmetry.
  function automatic logic signed [SW-1:0] sin_lu(input logic [T-1:0] ph);
    logic [1:0]          quad;
    logic [T-2:0]        idx;
    logic signed [SW-1:0] v;
    quad = ph[T-1:T-2];
    idx  = quad[0] ? (T-1)'(QN) - {1'b0, ph[T-3:0]} : {1'b0, ph[T-3:0]};
    v    = signed'({1'b0, qsin[idx]});
    return quad[1] ? -v : v;
  endfunction

  // Round half up back to the fraction width.
  function automatic logic signed [RW-1:0] rnd_p(input logic signed [PRW:0] v);
    logic signed [PRW:0] w;
    w = v + HALF_P;
    return RW'(w >>> FRAC_BITS);
  endfunction

  amb_recip #(
    .FRAC_BITS(FRAC_BITS)
  ) u_recip (
    .clk      (clk),
    .rst      (rst),
    .valid_in (valid_in),
    .item_in  (item),
    .valid_out(d_valid),
    .item_out (d_item),
    .rcp      (d_rcp),
    .zero     (d_zero)
  );

  // Valid bits of the rotation stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      valid_out <= 1'b0;
    end else begin
      v1        <= d_valid;
      v2        <= v1;
      v3        <= v2;
      valid_out <= v3;
    end
  end

  // Sine and cosine lookups; the scale, position and reciprocals ride alongside.
  always_ff @(posedge clk) begin
    sx1   <= sin_lu(d_item.rot_x_turns[15 -: T]);
    cx1   <= sin_lu(d_item.rot_x_turns[15 -: T] + QTR);
    sy1   <= sin_lu(d_item.rot_y_turns[15 -: T]);
    cy1   <= sin_lu(d_item.rot_y_turns[15 -: T] + QTR);
    sz1   <= sin_lu(d_item.rot_z_turns[15 -: T]);
    cz1   <= sin_lu(d_item.rot_z_turns[15 -: T] + QTR);
    side1 <= {d_item.scale_x, d_item.scale_y, d_item.scale_z,
              d_item.pos_x, d_item.pos_y, d_item.pos_z,
              d_rcp[0], d_rcp[1], d_rcp[2], d_zero};
  end

  // Products of Ry * Rx that are not trivially one or zero.
  always_ff @(posedge clk) begin
    m_sysx <= sy1 * sx1;
    m_sycx <= sy1 * cx1;
    m_cysx <= cy1 * sx1;
    m_cycx <= cy1 * cx1;
    sx2    <= sx1;
    cx2    <= cx1;
    sy2    <= sy1;
    cy2    <= cy1;
    sz2    <= sz1;
    cz2    <= cz1;
    side2  <= side1;
  end

  // Rounded T = Ry * Rx.
  always_comb begin
    t0[0] = RW'(cy2);
    t0[1] = rnd_p((PRW+1)'(m_sysx));
    t0[2] = rnd_p((PRW+1)'(m_sycx));
    t1[0] = '0;
    t1[1] = RW'(cx2);
    t1[2] = -RW'(sx2);
    t2[0] = -RW'(sy2);
    t2[1] = rnd_p((PRW+1)'(m_cysx));
    t2[2] = rnd_p((PRW+1)'(m_cycx));
  end

  // Products of Rz * T for the first two rows; the third row passes through.
  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      pa[j]  <= cz2 * t0[j];
      pb[j]  <= sz2 * t1[j];
      pc[j]  <= sz2 * t0[j];
      pd[j]  <= cz2 * t1[j];
      t2r[j] <= t2[j];
    end
    side3 <= side2;
  end

  // Rounded rotation rows.
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      r0[j] = rnd_p((PRW+1)'(pa[j]) - (PRW+1)'(pb[j]));
      r1[j] = rnd_p((PRW+1)'(pc[j]) + (PRW+1)'(pd[j]));
    end
  end

  // Packed work item: side fields on top, rotation entries row-major below.
  always_ff @(posedge clk) begin
    data_out <= {side3,
                 t2r[2], t2r[1], t2r[0],
                 r1[2], r1[1], r1[0],
                 r0[2], r0[1], r0[0]};
  end

endmodule

### rtl/amb_queue.sv
// Small register queue that decouples the front end from the column back end.
// Depends on nothing; the writer never pushes into a full queue.
module amb_queue #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] wdata,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem [DEPTH];
  logic [AW-1:0] wp;
  logic [AW-1:0] rp;
  logic [CW-1:0] cnt;

  assign empty = (cnt == '0);
  assign rdata = mem[rp];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) begin
        wp <= (wp == AW'(DEPTH - 1)) ? '0 : wp + 1'b1;
      end
      if (pop) begin
        rp <= (rp == AW'(DEPTH - 1)) ? '0 : rp + 1'b1;
      end
      if (push && !pop) begin
        cnt <= cnt + 1'b1;
      end else if (pop && !push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= wdata;
    end
  end

endmodule

### rtl/amb_back.sv
// Back end: walks the four columns of a work item and forms both matrices' entries.
// Depends on amb_pkg for the result type; one multiplier stage, then round and saturate.
module amb_back #(
  parameter int FRAC_BITS = 16,
  parameter int RW        = 19,
  parameter int ITEM_W    = 436
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_empty,
  input  logic [ITEM_W-1:0]  q_data,
  output logic               q_pop,
  output amb_pkg::out_item_t result,
  output logic               empty,
  input  logic               pop
);

  localparam int PW  = amb_pkg::POS_W;
  localparam int SCW = amb_pkg::SCALE_W;
  localparam int IPW = RW + PW;
  localparam int FPW = SCW + PW;
  localparam int AW  = 64;
  localparam logic signed [AW-1:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [AW-1:0] SMAX = 64'sh7FFFFFFF;
  localparam logic signed [AW-1:0] SMIN = -64'sh80000000;
  localparam logic signed [31:0]   ONE  = 32'sd1 <<< FRAC_BITS;
  localparam logic [1:0]           LAST_COL = 2'd3;

  logic [ITEM_W-1:0]     cur;
  logic                  cur_valid;
  logic [1:0]            col;
  logic [1:0]            csel;
  logic                  en;
  logic                  ov;

  logic signed [RW-1:0]  rm [3][3];
  logic signed [SCW-1:0] sc [3];
  logic signed [PW-1:0]  p  [3];
  logic signed [31:0]    rc [3];
  logic                  zr;

  logic signed [PW-1:0]  fb [3];
  logic signed [RW-1:0]  ia [3][3];
  logic signed [PW-1:0]  ib [3];

  logic                  s1_valid;
  logic [1:0]            s1_col;
  logic                  s1_zero;
  logic signed [FPW-1:0] fprod [3];
  logic signed [IPW-1:0] iprod [3][3];
  logic signed [31:0]    fv [3];
  logic signed [31:0]    iv [3];
  logic signed [AW-1:0]  isum [3];

  // Round half up, optionally negate, and saturate to 32 bits.
  function automatic logic signed [31:0] sat_rnd(input logic signed [AW-1:0] v, input logic ng);
    logic signed [AW-1:0] s;
    s = (v + HALF) >>> FRAC_BITS;
    if (ng) begin
      s = -s;
    end
    if (s > SMAX) begin
      return SMAX[31:0];
    end
    if (s < SMIN) begin
      return SMIN[31:0];
    end
    return s[31:0];
  endfunction

  assign en    = !ov || pop;
  assign empty = !ov;
  assign q_pop = !q_empty && (!cur_valid || (en && col == LAST_COL));
  assign csel  = (col == LAST_COL) ? 2'd0 : col;

  // Unpack the current work item.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        rm[i][j] = cur[(i*3+j)*RW +: RW];
      end
    end
    {sc[0], sc[1], sc[2], p[0], p[1], p[2], rc[0], rc[1], rc[2], zr} = cur[ITEM_W-1:9*RW];
  end

  // Operand selection for the column being issued.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      fb[i] = (col == LAST_COL) ? p[i] : PW'(rm[i][csel]);
      ib[i] = (col == LAST_COL) ? p[i] : rc[csel];
      for (int k = 0; k < 3; k++) begin
        if (col == LAST_COL) begin
          ia[i][k] = rm[k][i];
        end else begin
          ia[i][k] = (k == 0) ? rm[csel][i] : '0;
        end
      end
    end
  end

  // Column sequencer and stage valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      col       <= '0;
      s1_valid  <= 1'b0;
      ov        <= 1'b0;
    end else begin
      if (en) begin
        s1_valid <= cur_valid;
        ov       <= s1_valid;
        if (cur_valid) begin
          col <= col + 1'b1;
        end
      end
      if (q_pop) begin
        cur_valid <= 1'b1;
      end else if (en && cur_valid && col == LAST_COL) begin
        cur_valid <= 1'b0;
      end
    end
  end

  // Item load and the multiplier stage.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_data;
    end
    if (en && cur_valid) begin
      s1_col  <= col;
      s1_zero <= zr;
      for (int i = 0; i < 3; i++) begin
        fprod[i] <= sc[i] * fb[i];
        for (int k = 0; k < 3; k++) begin
          iprod[i][k] <= ia[i][k] * ib[k];
        end
      end
    end
  end

  // Rounding and saturation; the translation column of the inverse is negated.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      isum[i] = AW'(iprod[i][0]) + AW'(iprod[i][1]) + AW'(iprod[i][2]);
      fv[i]   = sat_rnd(AW'(fprod[i]), 1'b0);
      iv[i]   = sat_rnd(isum[i], s1_col == LAST_COL);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (en && s1_valid) begin
      result.column_index <= s1_col;
      result.fwd_e0       <= fv[0];
      result.fwd_e1       <= fv[1];
      result.fwd_e2       <= fv[2];
      result.fwd_e3       <= (s1_col == LAST_COL) ? ONE : '0;
      result.inv_e0       <= iv[0];
      result.inv_e1       <= iv[1];
      result.inv_e2       <= iv[2];
      result.inv_e3       <= (s1_col == LAST_COL) ? ONE : '0;
      result.zero_scale   <= s1_zero;
      result.last_column  <= (s1_col == LAST_COL);
    end
  end

endmodule

### rtl/affine_model_matrix_builder.sv
// Top level of the affine model matrix builder: front end, work queue and column back end.
// Depends on amb_pkg, amb_front, amb_queue and amb_back.
//
// Usage: the input side is a queue write port. A transaction (angles, position, scale)
// is taken on a clock edge with push high and full low. The output side is a queue read
// port: while empty is low, result holds the oldest column, and pop high takes it.
// Each input transaction yields four result transactions, columns 0 to 3 in order, with
// last_column set on column 3. Column j carries column j of the model matrix and of its
// inverse.
// Latency from input to the first column is set by the restoring reciprocal pipeline
// (one quotient bit per stage) plus the rotation stages.
// Throughput is set by the back end, which issues one column per cycle while the
// receiver does not stall it. The front end takes transactions in consecutive cycles
// until its credit of queue entries runs out, then raises full.
// Reset clears all valid bits and credits; no memory needs clearing. When the receiver
// holds pop low, the back end stalls and the queue fills, then full rises.
module affine_model_matrix_builder #(
  parameter int FRAC_BITS       = 16,
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  amb_pkg::in_item_t  item,
  output logic               empty,
  input  logic               pop,
  output amb_pkg::out_item_t result
);

  localparam int RW        = FRAC_BITS + 3;
  localparam int ITEM_W    = 9 * RW + 3 * amb_pkg::SCALE_W + 3 * amb_pkg::POS_W
                             + 3 * amb_pkg::ENTRY_W + 1;
  localparam int FRONT_LAT = 2 * FRAC_BITS + 7;
  localparam int QDEPTH    = FRONT_LAT / 4 + 4;
  localparam int CW        = $clog2(QDEPTH + 1);

  logic              accept;
  logic              f_valid;
  logic [ITEM_W-1:0] f_data;
  logic              q_pop;
  logic              q_empty;
  logic [ITEM_W-1:0] q_data;
  logic [CW-1:0]     outstanding;

  assign accept = push && !full;
  assign full   = (outstanding == CW'(QDEPTH));

  // Credit count: items in the front end or waiting in the queue.
  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
    end else if (accept && !q_pop) begin
      outstanding <= outstanding + 1'b1;
    end else if (q_pop && !accept) begin
      outstanding <= outstanding - 1'b1;
    end
  end

  amb_front #(
    .FRAC_BITS      (FRAC_BITS),
    .SINE_TABLE_BITS(SINE_TABLE_BITS),
    .RW             (RW),
    .ITEM_W         (ITEM_W)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .valid_in (accept),
    .item     (item),
    .valid_out(f_valid),
    .data_out (f_data)
  );

  amb_queue #(
    .W    (ITEM_W),
    .DEPTH(QDEPTH)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (f_valid),
    .wdata(f_data),
    .pop  (q_pop),
    .rdata(q_data),
    .empty(q_empty)
  );

  amb_back #(
    .FRAC_BITS(FRAC_BITS),
    .RW       (RW),
    .ITEM_W   (ITEM_W)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .q_empty(q_empty),
    .q_data (q_data),
    .q_pop  (q_pop),
    .result (result),
    .empty  (empty),
    .pop    (pop)
  );

endmodule

### rtl/amb_checker.sv
// Port-level checker for the affine model matrix builder, bound to the top level.
// Depends on amb_pkg for the transaction types.
module amb_checker (
  input logic               clk,
  input logic               rst,
  input logic               push,
  input logic               full,
  input amb_pkg::in_item_t  item,
  input logic               empty,
  input logic               pop,
  input amb_pkg::out_item_t result
);

  // Reset leaves no result pending and room for input.
  a_reset_idle: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("block not idle after reset");

  // A stalled result transaction holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result)))
    else $error("stalled result changed");

  // The last flag marks column 3 and only column 3.
  a_last: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (result.last_column == (result.column_index == 2'd3)))
    else $error("last_column does not match column_index");

  // Columns of one item follow in order and share the zero-scale flag.
  a_order: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop && !result.last_column) ##1 !empty |->
      ((result.column_index == 2'($past(result.column_index) + 2'd1)) &&
       (result.zero_scale == $past(result.zero_scale))))
    else $error("column sequence broken");

endmodule

bind affine_model_matrix_builder amb_checker u_amb_checker (
  .clk   (clk),
  .rst   (rst),
  .push  (push),
  .full  (full),
  .item  (item),
  .empty (empty),
  .pop   (pop),
  .result(result)
);
